>>> design/rsla_pkg.sv
// Package for the real-time clock, sensor logger and alarm block.
// Holds the shared types, register indexes, reset values and the time helper.
// Depends on nothing.
package rsla_pkg;

   localparam int CSR_ADDR_WIDTH = 5;

   localparam logic [4:0] MAX_HOURS   = 5'd23;
   localparam logic [5:0] MAX_MINUTES = 6'd59;
   localparam logic [5:0] MAX_SECONDS = 6'd59;

   typedef enum logic [1:0] {
      REQ_TICK   = 2'd0,
      REQ_SAMPLE = 2'd1,
      REQ_ACK    = 2'd2,
      REQ_SET    = 2'd3
   } rsla_req_kind_type;

   typedef enum logic [2:0] {
      REG_RING_LAST       = 3'd0,
      REG_ALARMS_ENABLED  = 3'd1,
      REG_ALARM_HOURS     = 3'd2,
      REG_ALARM_MINUTES   = 3'd3,
      REG_ALARM_SECONDS   = 3'd4,
      REG_TEMP_THRESHOLD  = 3'd5,
      REG_LIGHT_THRESHOLD = 3'd6
   } rsla_reg_index_type;

   typedef struct packed {
      logic [7:0] ring_last;
      logic       alarms_enabled;
      logic [4:0] alarm_hours;
      logic [5:0] alarm_minutes;
      logic [5:0] alarm_seconds;
      logic [5:0] temp_threshold;
      logic [2:0] light_threshold;
   } rsla_cfg_type;

   localparam rsla_cfg_type CFG_RESET = '{
      ring_last:       8'd25,
      alarms_enabled:  1'b0,
      alarm_hours:     5'd12,
      alarm_minutes:   6'd0,
      alarm_seconds:   6'd0,
      temp_threshold:  6'd28,
      light_threshold: 3'd4
   };

   typedef struct packed {
      logic [4:0] hours;
      logic [5:0] minutes;
      logic [5:0] seconds;
      logic [7:0] ring_index;
      logic [7:0] last_temp;
      logic [2:0] last_light;
      logic       last_valid;
      logic       clock_alarm_spent;
      logic [2:0] alarm_latches;
      logic [1:0] level_flags;
   } rsla_state_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] temp_sample;
      logic [2:0] light_sample;
      logic [4:0] set_hours;
      logic [5:0] set_minutes;
   } rsla_req_type;

   typedef struct packed {
      logic       log_valid;
      logic [7:0] log_slot;
      logic [4:0] log_hours;
      logic [5:0] log_minutes;
      logic [5:0] log_seconds;
      logic [7:0] log_temp;
      logic [2:0] log_light;
      logic       clock_alarm_latched;
      logic       temp_alarm_latched;
      logic       light_alarm_latched;
      logic       temp_over_now;
      logic       light_under_now;
   } rsla_rsp_type;

   function automatic logic [16:0] to_seconds(input logic [4:0] h, input logic [5:0] m,
                                              input logic [5:0] s);
      return 17'(h) * 17'd3600 + 17'(m) * 17'd60 + 17'(s);
   endfunction

endpackage

>>> design/rsla_step.sv
// Next-state and result logic for one transaction of the clock and logger.
// Depends on rsla_pkg.
module rsla_step (
   input  rsla_pkg::rsla_state_type state,
   input  rsla_pkg::rsla_cfg_type   cfg,
   input  rsla_pkg::rsla_req_type   req,
   output rsla_pkg::rsla_state_type next_state,
   output rsla_pkg::rsla_rsp_type   rsp
);
   import rsla_pkg::*;

   rsla_req_kind_type kind;
   logic [7:0]        slot_inc;
   logic [16:0]       alarm_total;
   logic              changed;

   assign kind        = rsla_req_kind_type'(req.kind);
   assign slot_inc    = state.ring_index + 8'd1;
   assign alarm_total = to_seconds(cfg.alarm_hours, cfg.alarm_minutes, cfg.alarm_seconds);
   assign changed     = !state.last_valid || (req.temp_sample != state.last_temp) ||
                        (req.light_sample != state.last_light);

   always_comb begin
      next_state = state;
      rsp        = '0;
      case (kind)
         REQ_TICK: begin
            if (state.seconds >= MAX_SECONDS) begin
               next_state.seconds = 6'd0;
               if (state.minutes >= MAX_MINUTES) begin
                  next_state.minutes = 6'd0;
                  next_state.hours   = (state.hours >= MAX_HOURS) ? 5'd0 : state.hours + 5'd1;
               end else begin
                  next_state.minutes = state.minutes + 6'd1;
               end
            end else begin
               next_state.seconds = state.seconds + 6'd1;
            end
            if (cfg.alarms_enabled && !state.clock_alarm_spent &&
                (to_seconds(next_state.hours, next_state.minutes, next_state.seconds) >=
                 alarm_total)) begin
               next_state.alarm_latches[0] = 1'b1;
               next_state.clock_alarm_spent = 1'b1;
            end
         end
         REQ_SAMPLE: begin
            if (changed) begin
               rsp.log_valid    = 1'b1;
               rsp.log_slot     = state.ring_index;
               rsp.log_hours    = state.hours;
               rsp.log_minutes  = state.minutes;
               rsp.log_seconds  = state.seconds;
               rsp.log_temp     = req.temp_sample;
               rsp.log_light    = req.light_sample;
               next_state.ring_index = (slot_inc > cfg.ring_last) ? 8'd0 : slot_inc;
               next_state.last_temp  = req.temp_sample;
               next_state.last_light = req.light_sample;
               next_state.last_valid = 1'b1;
            end
            if (cfg.alarms_enabled) begin
               if (req.light_sample < cfg.light_threshold) begin
                  next_state.level_flags[1]   = 1'b1;
                  next_state.alarm_latches[2] = 1'b1;
               end else begin
                  next_state.level_flags[1] = 1'b0;
               end
               if (req.temp_sample > {2'b00, cfg.temp_threshold}) begin
                  next_state.level_flags[0]   = 1'b1;
                  next_state.alarm_latches[1] = 1'b1;
               end else begin
                  next_state.level_flags[0] = 1'b0;
               end
            end
         end
         REQ_ACK: begin
            next_state.alarm_latches = 3'b000;
         end
         REQ_SET: begin
            next_state.hours   = (req.set_hours > MAX_HOURS) ? MAX_HOURS : req.set_hours;
            next_state.minutes = (req.set_minutes > MAX_MINUTES) ? MAX_MINUTES : req.set_minutes;
            next_state.seconds = 6'd0;
         end
         default: begin
            next_state = state;
         end
      endcase
      rsp.clock_alarm_latched = next_state.alarm_latches[0];
      rsp.temp_alarm_latched  = next_state.alarm_latches[1];
      rsp.light_alarm_latched = next_state.alarm_latches[2];
      rsp.temp_over_now       = next_state.level_flags[0];
      rsp.light_under_now     = next_state.level_flags[1];
   end

endmodule

>>> design/rtc_sensor_logger_alarm.sv
// Top level of the real-time clock with sensor change logger and alarms.
// Holds the registers, the APB register file and the output register; uses rsla_step.
// Depends on rsla_pkg and rsla_step.
//
//   channel   ports                        direction  moves
//   req       req_valid/req_ready, req_*   in         one request per transaction
//   rsp       rsp_valid/rsp_ready, rsp_*   out        one result per request
//   csr       psel, penable, pwrite, ...   in/out     register writes and reads
//
// One transaction per cycle unless rsp_ready stalls the output: each request is worked
// out combinationally from the state registers and lands in the output register,
// which frees as it is taken; rsp_valid rises in the cycle after acceptance.
// Reset is synchronous and restores the clock, logger state and register defaults.
// A stalled result holds; a new request is taken in the cycle the old one leaves.
module rtc_sensor_logger_alarm (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_type,
   input  logic [7:0]                         req_temp_sample,
   input  logic [2:0]                         req_light_sample,
   input  logic [4:0]                         req_set_hours,
   input  logic [5:0]                         req_set_minutes,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_log_valid,
   output logic [7:0]                         rsp_log_slot,
   output logic [4:0]                         rsp_log_hours,
   output logic [5:0]                         rsp_log_minutes,
   output logic [5:0]                         rsp_log_seconds,
   output logic [7:0]                         rsp_log_temp,
   output logic [2:0]                         rsp_log_light,
   output logic                               rsp_clock_alarm_latched,
   output logic                               rsp_temp_alarm_latched,
   output logic                               rsp_light_alarm_latched,
   output logic                               rsp_temp_over_now,
   output logic                               rsp_light_under_now,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [rsla_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [31:0]                        pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready
);
   import rsla_pkg::*;

   rsla_cfg_type       cfg_ff;
   rsla_cfg_type       cfg_in;
   rsla_state_type     state_ff;
   rsla_state_type     state_in;
   rsla_state_type     step_state;
   rsla_rsp_type       rsp_ff;
   rsla_rsp_type       step_rsp;
   rsla_req_type       req;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic               accept;
   logic               csr_write;
   logic               rearm;
   rsla_reg_index_type reg_index;

   assign pready    = 1'b1;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign csr_write = psel && penable && pwrite && pready;
   assign reg_index = rsla_reg_index_type'(paddr[CSR_ADDR_WIDTH-1:2]);

   assign req = '{
      kind:         req_type,
      temp_sample:  req_temp_sample,
      light_sample: req_light_sample,
      set_hours:    req_set_hours,
      set_minutes:  req_set_minutes
   };

   rsla_step u_step (
      .state      (state_ff),
      .cfg        (cfg_ff),
      .req        (req),
      .next_state (step_state),
      .rsp        (step_rsp)
   );

   always_comb begin
      cfg_in = cfg_ff;
      rearm  = 1'b0;
      if (csr_write) begin
         case (reg_index)
            REG_RING_LAST:       cfg_in.ring_last       = pwdata[7:0];
            REG_ALARMS_ENABLED:  cfg_in.alarms_enabled  = pwdata[0];
            REG_ALARM_HOURS:     cfg_in.alarm_hours     = pwdata[4:0];
            REG_ALARM_MINUTES:   cfg_in.alarm_minutes   = pwdata[5:0];
            REG_ALARM_SECONDS:   cfg_in.alarm_seconds   = pwdata[5:0];
            REG_TEMP_THRESHOLD:  cfg_in.temp_threshold  = pwdata[5:0];
            REG_LIGHT_THRESHOLD: cfg_in.light_threshold = pwdata[2:0];
            default:             cfg_in = cfg_ff;
         endcase
         rearm = reg_index inside {REG_ALARM_HOURS, REG_ALARM_MINUTES, REG_ALARM_SECONDS};
      end
   end

   always_comb begin
      case (reg_index)
         REG_RING_LAST:       prdata = {24'd0, cfg_ff.ring_last};
         REG_ALARMS_ENABLED:  prdata = {31'd0, cfg_ff.alarms_enabled};
         REG_ALARM_HOURS:     prdata = {27'd0, cfg_ff.alarm_hours};
         REG_ALARM_MINUTES:   prdata = {26'd0, cfg_ff.alarm_minutes};
         REG_ALARM_SECONDS:   prdata = {26'd0, cfg_ff.alarm_seconds};
         REG_TEMP_THRESHOLD:  prdata = {26'd0, cfg_ff.temp_threshold};
         REG_LIGHT_THRESHOLD: prdata = {29'd0, cfg_ff.light_threshold};
         default:             prdata = 32'd0;
      endcase
   end

   always_comb begin
      state_in = accept ? step_state : state_ff;
      if (rearm) begin
         state_in.clock_alarm_spent = 1'b0;
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= CFG_RESET;
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= step_rsp;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_log_valid           = rsp_ff.log_valid;
   assign rsp_log_slot            = rsp_ff.log_slot;
   assign rsp_log_hours           = rsp_ff.log_hours;
   assign rsp_log_minutes         = rsp_ff.log_minutes;
   assign rsp_log_seconds         = rsp_ff.log_seconds;
   assign rsp_log_temp            = rsp_ff.log_temp;
   assign rsp_log_light           = rsp_ff.log_light;
   assign rsp_clock_alarm_latched = rsp_ff.clock_alarm_latched;
   assign rsp_temp_alarm_latched  = rsp_ff.temp_alarm_latched;
   assign rsp_light_alarm_latched = rsp_ff.light_alarm_latched;
   assign rsp_temp_over_now       = rsp_ff.temp_over_now;
   assign rsp_light_under_now     = rsp_ff.light_under_now;

endmodule

>>> test/tb.sv
// Self-checking testbench for rtc_sensor_logger_alarm: clocked request driver and result
// monitor around a queue of pending requests, checked against an in-bench clock/logger model.
// Depends on rsla_pkg and the rtc_sensor_logger_alarm RTL.
`timescale 1ns / 100ps

module tb;
   import rsla_pkg::*;

   localparam int RESET_CYCLES = 11;
   localparam int LONG_HOLD    = 60;
   localparam int STALL_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 4;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_type = REQ_TICK;
   logic [7:0]  req_temp_sample = '0;
   logic [2:0]  req_light_sample = '0;
   logic [4:0]  req_set_hours = '0;
   logic [5:0]  req_set_minutes = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_log_valid;
   logic [7:0]  rsp_log_slot;
   logic [4:0]  rsp_log_hours;
   logic [5:0]  rsp_log_minutes;
   logic [5:0]  rsp_log_seconds;
   logic [7:0]  rsp_log_temp;
   logic [2:0]  rsp_log_light;
   logic        rsp_clock_alarm_latched;
   logic        rsp_temp_alarm_latched;
   logic        rsp_light_alarm_latched;
   logic        rsp_temp_over_now;
   logic        rsp_light_under_now;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   rtc_sensor_logger_alarm DUT (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_type                (req_type),
      .req_temp_sample         (req_temp_sample),
      .req_light_sample        (req_light_sample),
      .req_set_hours           (req_set_hours),
      .req_set_minutes         (req_set_minutes),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_log_valid           (rsp_log_valid),
      .rsp_log_slot            (rsp_log_slot),
      .rsp_log_hours           (rsp_log_hours),
      .rsp_log_minutes         (rsp_log_minutes),
      .rsp_log_seconds         (rsp_log_seconds),
      .rsp_log_temp            (rsp_log_temp),
      .rsp_log_light           (rsp_log_light),
      .rsp_clock_alarm_latched (rsp_clock_alarm_latched),
      .rsp_temp_alarm_latched  (rsp_temp_alarm_latched),
      .rsp_light_alarm_latched (rsp_light_alarm_latched),
      .rsp_temp_over_now       (rsp_temp_over_now),
      .rsp_light_under_now     (rsp_light_under_now),
      .psel                    (psel),
      .penable                 (penable),
      .pwrite                  (pwrite),
      .paddr                   (paddr),
      .pwdata                  (pwdata),
      .prdata                  (prdata),
      .pready                  (pready)
   );

   // model state
   rsla_cfg_type cfg_mirror = CFG_RESET;
   logic [4:0]   tod_hours = '0;
   logic [5:0]   tod_minutes = '0;
   logic [5:0]   tod_seconds = '0;
   logic [7:0]   next_slot = '0;
   logic [7:0]   prior_temp = '0;
   logic [2:0]   prior_light = '0;
   logic         prior_seen = 1'b0;
   logic         alarm_used = 1'b0;
   logic [2:0]   latch_bits = '0;
   logic [1:0]   level_bits = '0;

   rsla_req_type request_q[$];
   rsla_rsp_type status_q[$];

   logic [7:0]   gen_temp = '0;
   logic [2:0]   gen_light = '0;
   bit           idle_on = 1'b1;
   bit           long_hold_pending = 1'b0;
   int           send_gap = 0;
   int           hold_left = 0;
   int           quiet_cycles = 0;
   int           n_queued = 0;
   int           n_accepted = 0;
   int           n_checked = 0;
   int           n_logged = 0;
   int           n_alarm_seen = 0;
   int           n_csr_writes = 0;
   int           n_errors = 0;

   initial begin : clock_gen
      forever #4 clock = ~clock;
   end

   function automatic rsla_rsp_type status_after(input rsla_req_type rq);
      rsla_rsp_type rec;
      int           now_secs;
      int           alarm_secs;
      rec = '0;
      case (rsla_req_kind_type'(rq.kind))
         REQ_TICK: begin
            if (tod_seconds >= MAX_SECONDS) begin
               tod_seconds = '0;
               if (tod_minutes >= MAX_MINUTES) begin
                  tod_minutes = '0;
                  tod_hours = (tod_hours >= MAX_HOURS) ? 5'd0 : tod_hours + 5'd1;
               end else begin
                  tod_minutes = tod_minutes + 6'd1;
               end
            end else begin
               tod_seconds = tod_seconds + 6'd1;
            end
            now_secs = int'(tod_hours) * 3600 + int'(tod_minutes) * 60 + int'(tod_seconds);
            alarm_secs = int'(cfg_mirror.alarm_hours) * 3600 +
                         int'(cfg_mirror.alarm_minutes) * 60 + int'(cfg_mirror.alarm_seconds);
            if (cfg_mirror.alarms_enabled && !alarm_used && now_secs >= alarm_secs) begin
               latch_bits[0] = 1'b1;
               alarm_used = 1'b1;
            end
         end
         REQ_SAMPLE: begin
            if (!prior_seen || rq.temp_sample != prior_temp ||
                rq.light_sample != prior_light) begin
               rec.log_valid   = 1'b1;
               rec.log_slot    = next_slot;
               rec.log_hours   = tod_hours;
               rec.log_minutes = tod_minutes;
               rec.log_seconds = tod_seconds;
               rec.log_temp    = rq.temp_sample;
               rec.log_light   = rq.light_sample;
               next_slot = next_slot + 8'd1;
               if (next_slot > cfg_mirror.ring_last) begin
                  next_slot = '0;
               end
               prior_temp  = rq.temp_sample;
               prior_light = rq.light_sample;
               prior_seen  = 1'b1;
            end
            if (cfg_mirror.alarms_enabled) begin
               level_bits[1] = rq.light_sample < cfg_mirror.light_threshold;
               if (level_bits[1]) begin
                  latch_bits[2] = 1'b1;
               end
               level_bits[0] = rq.temp_sample > cfg_mirror.temp_threshold;
               if (level_bits[0]) begin
                  latch_bits[1] = 1'b1;
               end
            end
         end
         REQ_ACK: begin
            latch_bits = '0;
         end
         REQ_SET: begin
            tod_hours   = (rq.set_hours > MAX_HOURS) ? MAX_HOURS : rq.set_hours;
            tod_minutes = (rq.set_minutes > MAX_MINUTES) ? MAX_MINUTES : rq.set_minutes;
            tod_seconds = '0;
         end
         default: ;
      endcase
      rec.clock_alarm_latched = latch_bits[0];
      rec.temp_alarm_latched  = latch_bits[1];
      rec.light_alarm_latched = latch_bits[2];
      rec.temp_over_now       = level_bits[0];
      rec.light_under_now     = level_bits[1];
      return rec;
   endfunction

   task automatic flag_error(input string text);
      $display("MISMATCH: %s", text);
      n_errors++;
   endtask

   task automatic compare_field(input string name, input logic [7:0] got,
                                input logic [7:0] want);
      if (got !== want) begin
         flag_error($sformatf("result %0d %s is %0d, expected %0d", n_checked, name, got,
                              want));
      end
   endtask

   task automatic push_request(input rsla_req_kind_type kind, input logic [7:0] temp,
                               input logic [2:0] light, input logic [4:0] hours,
                               input logic [5:0] minutes);
      rsla_req_type rq;
      rq.kind         = kind;
      rq.temp_sample  = temp;
      rq.light_sample = light;
      rq.set_hours    = hours;
      rq.set_minutes  = minutes;
      request_q.push_back(rq);
      n_queued++;
      if (kind == REQ_SAMPLE) begin
         gen_temp  = temp;
         gen_light = light;
      end
   endtask

   task automatic push_noise(input rsla_req_kind_type kind);
      push_request(kind, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
                   5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)));
   endtask

   task automatic queue_mixed(input int count);
      int         target;
      int         pick;
      logic [4:0] hh;
      target = n_queued + count;
      while (n_queued < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            repeat ($urandom_range(1, 8)) push_noise(REQ_TICK);
         end else if (pick < 34) begin
            // run through the top of the hour, often the day rollover
            hh = ($urandom_range(0, 1) != 0) ? MAX_HOURS : 5'($urandom_range(0, 31));
            push_request(REQ_SET, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)), hh,
                         MAX_MINUTES);
            repeat ($urandom_range(60, 62)) push_noise(REQ_TICK);
         end else if (pick < 44) begin
            push_request(REQ_SET, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
                         cfg_mirror.alarm_hours, cfg_mirror.alarm_minutes);
            repeat ($urandom_range(1, 12)) push_noise(REQ_TICK);
         end else if (pick < 74) begin
            repeat ($urandom_range(1, 4)) begin
               if ($urandom_range(0, 9) >= 4) begin
                  gen_temp  = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 63))
                                                          : 8'($urandom_range(0, 255));
                  gen_light = 3'($urandom_range(0, 7));
               end
               push_request(REQ_SAMPLE, gen_temp, gen_light, 5'($urandom_range(0, 31)),
                            6'($urandom_range(0, 63)));
            end
         end else if (pick < 82) begin
            push_noise(REQ_ACK);
         end else if (pick < 90) begin
            push_noise(REQ_SET);
         end else begin
            push_noise(rsla_req_kind_type'($urandom_range(0, 3)));
         end
      end
   endtask

   task automatic queue_sample_changes(input int count);
      logic [7:0] tt;
      logic [2:0] ll;
      repeat (count) begin
         tt = 8'($urandom_range(0, 255));
         ll = 3'($urandom_range(0, 7));
         if (tt == gen_temp && ll == gen_light) begin
            ll = ll ^ 3'd1;
         end
         push_request(REQ_SAMPLE, tt, ll, 5'($urandom_range(0, 31)),
                      6'($urandom_range(0, 63)));
      end
   endtask

   task automatic wait_drained();
      while (n_checked < n_queued) @(posedge clock);
   endtask

   task automatic csr_write(input rsla_reg_index_type idx, input logic [31:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      n_csr_writes++;
      case (idx)
         REG_RING_LAST:       cfg_mirror.ring_last = value[7:0];
         REG_ALARMS_ENABLED:  cfg_mirror.alarms_enabled = value[0];
         REG_ALARM_HOURS: begin
            cfg_mirror.alarm_hours = value[4:0];
            alarm_used = 1'b0;
         end
         REG_ALARM_MINUTES: begin
            cfg_mirror.alarm_minutes = value[5:0];
            alarm_used = 1'b0;
         end
         REG_ALARM_SECONDS: begin
            cfg_mirror.alarm_seconds = value[5:0];
            alarm_used = 1'b0;
         end
         REG_TEMP_THRESHOLD:  cfg_mirror.temp_threshold = value[5:0];
         REG_LIGHT_THRESHOLD: cfg_mirror.light_threshold = value[2:0];
         default: ;
      endcase
   endtask

   always @(posedge clock) begin : request_driver
      rsla_req_type nxt;
      logic         offer;
      if (!reset) begin
         if (req_valid && req_ready) begin
            status_q.push_back(status_after(rsla_req_type'({req_type, req_temp_sample,
               req_light_sample, req_set_hours, req_set_minutes})));
            n_accepted++;
         end
         if (!req_valid || req_ready) begin
            offer = 1'b0;
            nxt = '0;
            if (send_gap > 0) begin
               send_gap--;
            end else if (request_q.size() != 0 && idle_on && $urandom_range(0, 9) == 0) begin
               send_gap = $urandom_range(0, 18);
            end else if (request_q.size() != 0) begin
               nxt = request_q.pop_front();
               offer = 1'b1;
            end
            req_valid <= offer;
            if (offer) begin
               req_type         <= nxt.kind;
               req_temp_sample  <= nxt.temp_sample;
               req_light_sample <= nxt.light_sample;
               req_set_hours    <= nxt.set_hours;
               req_set_minutes  <= nxt.set_minutes;
            end
         end
      end
   end

   always @(posedge clock) begin : result_monitor
      rsla_rsp_type want;
      logic         ready_next;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (status_q.size() == 0) begin
               flag_error("result transaction with no request outstanding");
            end else begin
               want = status_q.pop_front();
               compare_field("log_valid", rsp_log_valid, want.log_valid);
               compare_field("log_slot", rsp_log_slot, want.log_slot);
               compare_field("log_hours", rsp_log_hours, want.log_hours);
               compare_field("log_minutes", rsp_log_minutes, want.log_minutes);
               compare_field("log_seconds", rsp_log_seconds, want.log_seconds);
               compare_field("log_temp", rsp_log_temp, want.log_temp);
               compare_field("log_light", rsp_log_light, want.log_light);
               compare_field("clock_alarm_latched", rsp_clock_alarm_latched,
                             want.clock_alarm_latched);
               compare_field("temp_alarm_latched", rsp_temp_alarm_latched,
                             want.temp_alarm_latched);
               compare_field("light_alarm_latched", rsp_light_alarm_latched,
                             want.light_alarm_latched);
               compare_field("temp_over_now", rsp_temp_over_now, want.temp_over_now);
               compare_field("light_under_now", rsp_light_under_now, want.light_under_now);
               if (want.log_valid) begin
                  n_logged++;
               end
               if (want.clock_alarm_latched) begin
                  n_alarm_seen++;
               end
               n_checked++;
            end
         end
         // hold off the result channel, long once on request, else in short bursts while idle_on is set
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            hold_left = LONG_HOLD - 1;
            ready_next = 1'b0;
         end else if (idle_on && $urandom_range(0, 11) == 0) begin
            hold_left = $urandom_range(0, 18);
            ready_next = 1'b0;
         end else begin
            ready_next = 1'b1;
         end
         rsp_ready <= ready_next;
      end
   end

   always @(posedge clock) begin : watchdog
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", quiet_cycles);
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin : sequencer
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset settings, alarms off
      push_request(REQ_TICK, 8'd255, 3'd7, 5'd31, 6'd63);
      push_request(REQ_SAMPLE, 8'd0, 3'd0, 5'd0, 6'd0);
      push_request(REQ_SAMPLE, 8'd0, 3'd0, 5'd31, 6'd63);
      push_request(REQ_SAMPLE, 8'd255, 3'd7, 5'd0, 6'd0);
      push_request(REQ_SAMPLE, 8'd255, 3'd0, 5'd0, 6'd0);
      push_request(REQ_SAMPLE, 8'd0, 3'd7, 5'd0, 6'd0);
      push_request(REQ_ACK, 8'd255, 3'd7, 5'd31, 6'd63);
      push_request(REQ_SET, 8'd0, 3'd0, 5'd31, 6'd63);
      push_request(REQ_TICK, 8'd0, 3'd0, 5'd0, 6'd0);
      push_request(REQ_SET, 8'd255, 3'd7, 5'd0, 6'd0);
      push_request(REQ_SAMPLE, 8'd0, 3'd7, 5'd0, 6'd0);
      queue_mixed(25);
      wait_drained();

      csr_write(REG_RING_LAST, 32'd0);
      csr_write(REG_ALARMS_ENABLED, 32'd1);
      csr_write(REG_ALARM_HOURS, 32'd0);
      csr_write(REG_ALARM_MINUTES, 32'd1);
      csr_write(REG_ALARM_SECONDS, 32'd0);
      csr_write(REG_TEMP_THRESHOLD, 32'd0);
      csr_write(REG_LIGHT_THRESHOLD, 32'd7);
      push_request(REQ_SAMPLE, 8'd0, 3'd7, 5'd0, 6'd0);
      push_request(REQ_SAMPLE, 8'd1, 3'd6, 5'd0, 6'd0);
      push_request(REQ_SAMPLE, 8'd1, 3'd6, 5'd0, 6'd0);
      push_request(REQ_SAMPLE, 8'd0, 3'd7, 5'd0, 6'd0);
      push_request(REQ_ACK, 8'd0, 3'd0, 5'd0, 6'd0);
      push_request(REQ_SET, 8'd0, 3'd0, 5'd0, 6'd1);
      push_request(REQ_TICK, 8'd0, 3'd0, 5'd0, 6'd0);
      push_request(REQ_TICK, 8'd0, 3'd0, 5'd0, 6'd0);
      push_request(REQ_ACK, 8'd0, 3'd0, 5'd0, 6'd0);
      push_request(REQ_TICK, 8'd0, 3'd0, 5'd0, 6'd0);
      push_request(REQ_SAMPLE, 8'd255, 3'd0, 5'd0, 6'd0);
      queue_mixed(50);
      wait_drained();

      // widest ring, alarm time beyond the end of the day
      csr_write(REG_RING_LAST, 32'd255);
      csr_write(REG_ALARM_HOURS, 32'd31);
      csr_write(REG_ALARM_MINUTES, 32'd63);
      csr_write(REG_ALARM_SECONDS, 32'd63);
      csr_write(REG_TEMP_THRESHOLD, 32'd63);
      csr_write(REG_LIGHT_THRESHOLD, 32'd0);
      queue_sample_changes(260);
      wait_drained();

      // lower the ring end below the current slot, stall the result side
      csr_write(REG_RING_LAST, 32'd3);
      csr_write(REG_ALARM_HOURS, $urandom_range(0, 23));
      csr_write(REG_ALARM_MINUTES, $urandom_range(0, 59));
      csr_write(REG_ALARM_SECONDS, $urandom_range(0, 10));
      csr_write(REG_TEMP_THRESHOLD, $urandom_range(0, 50));
      csr_write(REG_LIGHT_THRESHOLD, $urandom_range(0, 7));
      long_hold_pending = 1'b1;
      queue_mixed(60);
      wait_drained();

      idle_on = 1'b0;
      csr_write(REG_ALARMS_ENABLED, 32'd0);
      csr_write(REG_RING_LAST, $urandom_range(0, 255));
      csr_write(REG_ALARM_HOURS, $urandom_range(0, 31));
      csr_write(REG_ALARM_MINUTES, $urandom_range(0, 63));
      csr_write(REG_ALARM_SECONDS, $urandom_range(0, 63));
      csr_write(REG_TEMP_THRESHOLD, $urandom_range(0, 63));
      csr_write(REG_LIGHT_THRESHOLD, $urandom_range(0, 7));
      queue_mixed(45);
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Summary: %0d requests sent, %0d results checked over %0d register writes",
               n_accepted, n_checked, n_csr_writes);
      $display("Summary: %0d log records, %0d results with the clock alarm latched",
               n_logged, n_alarm_seen);
      if (n_errors == 0 && status_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

>>> rtc_sensor_logger_alarm.f
design/rsla_pkg.sv
design/rsla_step.sv
design/rtc_sensor_logger_alarm.sv
test/tb.sv
